@@ rtl/core/nscf_pkg.sv @@
// Shared types, codes and constants for the NMEA sentence capture filter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package nscf_pkg;

  // Field widths of the request and result items
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 7;
  localparam int LEN_W   = 7;
  localparam int EV_W    = 2;

  // Default line store depth in bytes
  localparam int LINE_DEPTH_DEF = 128;

  // Sentence tag length and line terminator
  localparam int                TAG_LEN = 6;
  localparam logic [BYTE_W-1:0] LF_CHAR = 8'h0A;

  // Request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_RX      = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  // Line end events
  typedef enum logic [EV_W-1:0] {
    EV_NONE     = 2'd0,
    EV_STORED   = 2'd1,
    EV_DROP_TAG = 2'd2,
    EV_DROP_RMC = 2'd3
  } line_ev_t;

  // Mailbox status seen by the line assembler
  typedef struct packed {
    logic full;
    logic rmc;
  } mb_status_t;

  // Line end summary handed to the mailbox
  typedef struct packed {
    logic fin;    // a line ended on this item
    logic store;  // it goes to the mailbox
    logic rmc;    // it carries the RMC tag
  } line_end_t;

  // Line store write request
  typedef struct packed {
    logic              we;
    logic [BYTE_W-1:0] data;
  } line_wr_t;

  // "$GPGGA" by position
  function automatic logic [BYTE_W-1:0] tag_gga_char(input logic [2:0] pos);
    logic [BYTE_W-1:0] c;
    unique case (pos)
      3'd0:    c = 8'h24;  // $
      3'd1:    c = 8'h47;  // G
      3'd2:    c = 8'h50;  // P
      3'd3:    c = 8'h47;  // G
      3'd4:    c = 8'h47;  // G
      3'd5:    c = 8'h41;  // A
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "$GPRMC" by position
  function automatic logic [BYTE_W-1:0] tag_rmc_char(input logic [2:0] pos);
    logic [BYTE_W-1:0] c;
    unique case (pos)
      3'd0:    c = 8'h24;  // $
      3'd1:    c = 8'h47;  // G
      3'd2:    c = 8'h50;  // P
      3'd3:    c = 8'h52;  // R
      3'd4:    c = 8'h4D;  // M
      3'd5:    c = 8'h43;  // C
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/nscf_if.sv @@
// Valid/ready channel interfaces for request and result items.
// Depends on nscf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface nscf_req_if import nscf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] rx_byte;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, opcode, rx_byte, read_index, input ready);
  modport sink   (input valid, opcode, rx_byte, read_index, output ready);
endinterface

interface nscf_rsp_if import nscf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic              message_ready;
  logic [LEN_W-1:0]  message_length;
  logic              message_is_rmc;
  logic [EV_W-1:0]   line_event;

  modport source (output valid, read_byte, message_ready, message_length,
                  message_is_rmc, line_event, input ready);
  modport sink   (input valid, read_byte, message_ready, message_length,
                  message_is_rmc, line_event, output ready);
endinterface

`default_nettype wire

@@ rtl/core/nmea_sentence_capture_filter.sv @@
// NMEA sentence capture filter top level: handshake and result register.
// Depends on nscf_pkg, nscf_if, nscf_line_asm and nscf_mailbox.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request item per cycle (receive byte, read mailbox byte, release
// mailbox) and returns exactly one result item for each, in the cycle after it
// is accepted; a new request is taken in every cycle while the result side
// keeps up, and also while a finished result is being taken. Received bytes
// build a line in one bank of a two-bank line memory; a line that starts
// with $GPGGA or $GPRMC becomes the mailbox by swapping banks, so no copy is
// made. Reads come from the mailbox bank through its single registered read
// port. The memory needs no clearing pass after reset: only bytes below the
// mailbox length are ever returned, and those were all written.
module nmea_sentence_capture_filter import nscf_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  nscf_req_if.sink  req,
  nscf_rsp_if.source rsp
);

  localparam int AW = $clog2(LINE_DEPTH);

  logic          accept;
  logic          rx_go;
  logic          rd_go;
  logic          rel_go;
  logic          rsp_valid;
  line_ev_t      ev;
  line_ev_t      ev_next;

  line_wr_t      wr;
  logic [AW-1:0] wr_addr;
  line_end_t     line_end;
  logic [AW-1:0] line_len;
  mb_status_t    mb_status;

  // Request decode; the result register frees up as it is taken
  always_comb begin
    req.ready = !rsp_valid || rsp.ready;
    accept    = req.valid && req.ready;
    rx_go     = accept && (op_t'(req.opcode) == OP_RX);
    rd_go     = accept && (op_t'(req.opcode) == OP_READ);
    rel_go    = accept && (op_t'(req.opcode) == OP_RELEASE);
  end

  nscf_line_asm #(
    .LINE_DEPTH (LINE_DEPTH),
    .AW         (AW)
  ) u_line_asm (
    .clk        (clk),
    .rst        (rst),
    .rx_go      (rx_go),
    .rx_byte    (req.rx_byte),
    .mb_status  (mb_status),
    .wr         (wr),
    .wr_addr    (wr_addr),
    .line_end   (line_end),
    .line_len   (line_len),
    .event_code (ev_next)
  );

  nscf_mailbox #(
    .LINE_DEPTH (LINE_DEPTH),
    .AW         (AW)
  ) u_mailbox (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .wr_addr    (wr_addr),
    .line_end   (line_end),
    .line_len   (line_len),
    .item_go    (accept),
    .rd_go      (rd_go),
    .rd_index   (req.read_index),
    .rel_go     (rel_go),
    .mb_status  (mb_status),
    .length_out (rsp.message_length),
    .rd_byte    (rsp.read_byte)
  );

  // Result register; mailbox status registers move only on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      ev        <= EV_NONE;
    end else begin
      if (accept) begin
        rsp_valid <= 1'b1;
        ev        <= ev_next;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    rsp.valid          = rsp_valid;
    rsp.message_ready  = mb_status.full;
    rsp.message_is_rmc = mb_status.rmc;
    rsp.line_event     = ev;
  end

`ifndef SYNTHESIS
  a_ev_only_rx: assert property (@(posedge clk) disable iff (rst)
    (accept && !rx_go) |=> (ev == EV_NONE))
    else $error("line event on a non-receive item");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted item produced no result");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.ready) |=> rsp_valid && $stable(ev))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

@@ rtl/core/nscf_line_asm.sv @@
// Line assembler: byte count, tag prefix tracking, line end decision.
// Depends on nscf_pkg; drives the write side of the mailbox banks.
`timescale 1ns / 1ps
`default_nettype none

module nscf_line_asm import nscf_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF,
  parameter int AW         = $clog2(LINE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rx_go,     // accepted receive item
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire mb_status_t        mb_status,
  output line_wr_t               wr,
  output logic [AW-1:0]          wr_addr,
  output line_end_t              line_end,
  output logic [AW-1:0]          line_len,
  output line_ev_t               event_code
);

  logic [AW-1:0] count;
  logic          gga_m;
  logic          rmc_m;

  logic          at_limit;
  logic          ends;
  logic          in_tag;
  logic          long_enough;
  logic          is_gga;
  logic          is_rmc;

  // Line end and tag decode
  always_comb begin
    at_limit    = (count == AW'(LINE_DEPTH - 2));
    ends        = at_limit || (rx_byte == LF_CHAR);
    in_tag      = (count < AW'(TAG_LEN));
    long_enough = !in_tag;
    is_gga      = long_enough && gga_m;
    is_rmc      = long_enough && rmc_m;

    line_end.fin   = rx_go && ends;
    line_end.store = line_end.fin && !(mb_status.full && mb_status.rmc) &&
                     (is_gga || is_rmc);
    line_end.rmc   = is_rmc;
    line_len       = count + AW'(1);

    wr.we   = rx_go;
    wr.data = ends ? LF_CHAR : rx_byte;
    wr_addr = count;

    priority if (!line_end.fin) begin
      event_code = EV_NONE;
    end else if (mb_status.full && mb_status.rmc) begin
      event_code = EV_DROP_RMC;
    end else if (is_gga || is_rmc) begin
      event_code = EV_STORED;
    end else begin
      event_code = EV_DROP_TAG;
    end
  end

  // Count and prefix match flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      gga_m <= 1'b1;
      rmc_m <= 1'b1;
    end else if (rx_go) begin
      if (ends) begin
        count <= '0;
        gga_m <= 1'b1;
        rmc_m <= 1'b1;
      end else begin
        count <= count + AW'(1);
        if (in_tag) begin
          if (rx_byte != tag_gga_char(count[2:0])) gga_m <= 1'b0;
          if (rx_byte != tag_rmc_char(count[2:0])) rmc_m <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= AW'(LINE_DEPTH - 2))
    else $error("line count past limit");

  a_fin_restart: assert property (@(posedge clk) disable iff (rst)
    line_end.fin |=> (count == '0) && gga_m && rmc_m)
    else $error("line did not restart after its end");

  a_store_needs_fin: assert property (@(posedge clk) disable iff (rst)
    line_end.store |-> line_end.fin && (event_code == EV_STORED))
    else $error("mailbox store without a line end");
`endif

endmodule

`default_nettype wire

@@ rtl/core/nscf_mailbox.sv @@
// Mailbox: two line banks swapped on store, length and status, byte reads.
// Depends on nscf_pkg; written by nscf_line_asm.
`timescale 1ns / 1ps
`default_nettype none

module nscf_mailbox import nscf_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF,
  parameter int AW         = $clog2(LINE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire line_wr_t          wr,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire line_end_t         line_end,
  input  wire logic [AW-1:0]     line_len,
  input  wire logic              item_go,   // accepted item of any kind
  input  wire logic              rd_go,     // accepted read item
  input  wire logic [IDX_W-1:0]  rd_index,
  input  wire logic              rel_go,    // accepted release item
  output mb_status_t             mb_status,
  output logic [LEN_W-1:0]       length_out,
  output logic [BYTE_W-1:0]      rd_byte
);

  localparam int CW = (AW > IDX_W) ? AW : IDX_W;

  // Bank wbank collects the line, the other one is the mailbox
  logic [BYTE_W-1:0] mem [0:1][0:LINE_DEPTH-1];
  logic              wbank;
  logic [AW-1:0]     length;
  logic              full;
  logic              rmc;
  logic [BYTE_W-1:0] rd_q;
  logic              rd_hit;

  logic [CW-1:0]     idx_w;
  logic [CW-1:0]     len_w;
  logic [AW-1:0]     rd_addr;

  always_comb begin
    idx_w   = CW'(rd_index);
    len_w   = CW'(length);
    rd_addr = idx_w[AW-1:0];
  end

  // Bank memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wbank][wr_addr] <= wr.data;
    end
    if (rd_go) begin
      rd_q <= mem[~wbank][rd_addr];
    end
  end

  // Mailbox state; the read hit flag follows every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      wbank  <= 1'b0;
      length <= '0;
      full   <= 1'b0;
      rmc    <= 1'b0;
      rd_hit <= 1'b0;
    end else begin
      if (line_end.store) begin
        wbank  <= ~wbank;
        length <= line_len;
        full   <= 1'b1;
        rmc    <= line_end.rmc;
      end else if (rel_go) begin
        full   <= 1'b0;
      end
      if (item_go) begin
        rd_hit <= rd_go && (idx_w < len_w);
      end
    end
  end

  always_comb begin
    mb_status.full = full;
    mb_status.rmc  = rmc;
    length_out     = len_w[LEN_W-1:0];
    rd_byte        = rd_hit ? rd_q : '0;
  end

`ifndef SYNTHESIS
  a_store_swaps: assert property (@(posedge clk) disable iff (rst)
    line_end.store |=> full && (wbank != $past(wbank)))
    else $error("store did not swap banks");

  a_bank_steady: assert property (@(posedge clk) disable iff (rst)
    !line_end.store |=> $stable(wbank))
    else $error("bank swapped without a store");

  a_release: assert property (@(posedge clk) disable iff (rst)
    (rel_go && !line_end.store) |=> !full)
    else $error("release left the mailbox full");
`endif

endmodule

`default_nettype wire

@@ tb/nmea_sentence_capture_filter_test.sv @@
// Self-checking testbench for nmea_sentence_capture_filter: drives request items,
// predicts every result item and compares it field by field.
// Depends on nscf_pkg, nscf_if and the RTL of the block.
`timescale 1ns / 1ps

module nmea_sentence_capture_filter_test;
  import nscf_pkg::*;

  localparam int          DEPTH      = LINE_DEPTH_DEF;
  localparam int          FULL_COUNT = DEPTH - 2;
  localparam int          ITEM_GOAL  = 1750;
  localparam int          DRAIN_CYC  = 8;
  localparam logic [47:0] GGA_TAG    = "$GPGGA";
  localparam logic [47:0] RMC_TAG    = "$GPRMC";

  // One result item as seen on the response channel
  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              ready;
    logic [LEN_W-1:0]  length;
    logic              rmc;
    line_ev_t          ev;
  } status_t;

  // Tracks line and mailbox state and checks result items in order
  class nmea_mailbox_scoreboard;
    logic [BYTE_W-1:0] line_buf [DEPTH];
    logic [BYTE_W-1:0] mb_buf [DEPTH];
    int                line_count;
    bit                gga_ok;
    bit                rmc_ok;
    int                mb_len;
    bit                mb_full;
    bit                mb_rmc;
    status_t           awaited[$];
    int                mismatches;
    int                results_seen;
    int                ev_seen [4];

    function new();
      line_count = 0;
      gga_ok     = 1'b1;
      rmc_ok     = 1'b1;
      mb_len     = 0;
      mb_full    = 1'b0;
      mb_rmc     = 1'b0;
      mismatches = 0;
      results_seen = 0;
      foreach (ev_seen[i]) ev_seen[i] = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int mailbox_length();
      return mb_len;
    endfunction

    // Terminate the current line and decide where it goes
    function line_ev_t close_line();
      bit       long_enough;
      bit       is_gga;
      bit       is_rmc;
      line_ev_t ev;
      long_enough = (line_count >= TAG_LEN);
      is_gga = long_enough && gga_ok;
      is_rmc = long_enough && rmc_ok;
      line_buf[line_count] = LF_CHAR;
      if (mb_full && mb_rmc) begin
        ev = EV_DROP_RMC;
      end else if (is_gga || is_rmc) begin
        for (int i = 0; i <= line_count; i++) mb_buf[i] = line_buf[i];
        mb_len  = line_count + 1;
        mb_full = 1'b1;
        mb_rmc  = is_rmc;
        ev = EV_STORED;
      end else begin
        ev = EV_DROP_TAG;
      end
      line_count = 0;
      gga_ok = 1'b1;
      rmc_ok = 1'b1;
      return ev;
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b,
                               logic [IDX_W-1:0] idx);
      status_t want;
      want.read_byte = '0;
      want.ev = EV_NONE;
      case (op)
        OP_RX: begin
          if (line_count < FULL_COUNT && b != LF_CHAR) begin
            if (line_count < TAG_LEN) begin
              if (b != GGA_TAG[47-8*line_count -: 8]) gga_ok = 1'b0;
              if (b != RMC_TAG[47-8*line_count -: 8]) rmc_ok = 1'b0;
            end
            line_buf[line_count] = b;
            line_count++;
          end else begin
            want.ev = close_line();
          end
        end
        OP_READ: if (int'(idx) < mb_len) want.read_byte = mb_buf[idx];
        OP_RELEASE: mb_full = 1'b0;
        default: ;
      endcase
      want.ready  = mb_full;
      want.length = LEN_W'(mb_len);
      want.rmc    = mb_rmc;
      awaited.push_back(want);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(status_t got);
      status_t want;
      string   bad;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result item with no request outstanding", $realtime);
        return;
      end
      want = awaited.pop_front();
      ev_seen[want.ev]++;
      bad = "";
      if (got.read_byte !== want.read_byte) bad = {bad, " read_byte"};
      if (got.ready !== want.ready) bad = {bad, " message_ready"};
      if (got.length !== want.length) bad = {bad, " message_length"};
      if (got.rmc !== want.rmc) bad = {bad, " message_is_rmc"};
      if (got.ev !== want.ev) bad = {bad, " line_event"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result %0d wrong in%s: exp byte=%h rdy=%b len=%0d rmc=%b ev=%0d",
                   $realtime, results_seen, bad, want.read_byte, want.ready,
                   want.length, want.rmc, want.ev);
          $display("    got byte=%h rdy=%b len=%0d rmc=%b ev=%0d",
                   got.read_byte, got.ready, got.length, got.rmc, got.ev);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  nscf_req_if req_ch ();
  nscf_rsp_if rsp_ch ();

  nmea_sentence_capture_filter u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  nmea_mailbox_scoreboard sb;
  int items_sent;
  int tx_left, rx_left;
  bit tx_quiet, rx_quiet;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Per-item wait, with stretches of back-to-back traffic
  function automatic int next_gap(ref int left, ref bit quiet);
    if (left <= 0) begin
      quiet = ($urandom_range(0, 2) == 0);
      left  = $urandom_range(30, 120);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // Present one request item and wait until it is taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                           input logic [IDX_W-1:0] idx);
    int gap;
    gap = next_gap(tx_left, tx_quiet);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.rx_byte    <= b;
    req_ch.read_index <= idx;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, b, idx);
    items_sent++;
  endtask

  task automatic rx(input logic [BYTE_W-1:0] b);
    send_item(OP_RX, b, IDX_W'($urandom));
  endtask

  task automatic read_at(input logic [IDX_W-1:0] idx);
    send_item(OP_READ, BYTE_W'($urandom), idx);
  endtask

  // Mostly any byte but line feed, now and then any byte at all
  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] c;
    if ($urandom_range(0, 19) == 0) return BYTE_W'($urandom);
    do c = BYTE_W'($urandom); while (c == LF_CHAR);
    return c;
  endfunction

  // Consumer side: reads biased to the held sentence, releases, no-ops
  task automatic consumer_op();
    int r;
    int len;
    r   = $urandom_range(0, 9);
    len = sb.mailbox_length();
    if (r < 4 && len > 0) read_at(IDX_W'($urandom_range(0, len - 1)));
    else if (r < 6) read_at(IDX_W'($urandom));
    else if (r < 8) send_item(OP_RELEASE, BYTE_W'($urandom), IDX_W'($urandom));
    else if (r == 8) send_item(OP_NOP, BYTE_W'($urandom), IDX_W'($urandom));
    else read_at({IDX_W{1'b1}});
  endtask

  // One line: wanted tag, corrupted tag, short line or junk, then payload (a short line has none)
  task automatic send_line();
    int                kind;
    int                pos;
    int                n;
    int                body_len;
    logic [47:0]       tag;
    logic [BYTE_W-1:0] c;
    kind = $urandom_range(0, 9);
    tag  = (kind < 4) ? GGA_TAG : (kind < 7) ? RMC_TAG :
           ($urandom_range(0, 1) ? GGA_TAG : RMC_TAG);
    if (kind <= 7) begin
      pos = $urandom_range(0, TAG_LEN - 1);
      for (int i = 0; i < TAG_LEN; i++) begin
        c = tag[47-8*i -: 8];
        if (kind == 7 && i == pos) c = c ^ BYTE_W'($urandom_range(1, 255));
        rx(c);
      end
    end else if (kind == 8) begin
      // short line: a tag prefix that ends too early
      n = $urandom_range(0, TAG_LEN - 1);
      for (int i = 0; i < n; i++) rx(tag[47-8*i -: 8]);
      rx(LF_CHAR);
      return;
    end else begin
      n = $urandom_range(0, TAG_LEN);
      repeat (n) rx(text_byte());
    end
    body_len = ($urandom_range(0, 24) == 0) ? $urandom_range(110, 135)
                                            : $urandom_range(0, 24);
    for (int i = 0; i < body_len; i++) begin
      if ($urandom_range(0, 14) == 0) consumer_op();
      rx(text_byte());
    end
    rx(LF_CHAR);
  endtask

  // Response side: random stalls, check each taken result
  initial begin
    status_t got;
    int      gap;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      gap = next_gap(rx_left, rx_quiet);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      got.read_byte = rsp_ch.read_byte;
      got.ready     = rsp_ch.message_ready;
      got.length    = rsp_ch.message_length;
      got.rmc       = rsp_ch.message_is_rmc;
      got.ev        = line_ev_t'(rsp_ch.line_event);
      sb.check_result(got);
    end
  end

  // Stimulus and end of run
  initial begin
    sb = new();
    items_sent = 0;
    tx_left = 0;
    rx_left = 0;
    rst <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= OP_NOP;
    req_ch.rx_byte    <= '0;
    req_ch.read_index <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: RMC stored, reads in and past it, GGA dropped while RMC held, release, no-op,
    // short line of extreme bytes, read after release
    for (int i = 0; i < TAG_LEN; i++) rx(RMC_TAG[47-8*i -: 8]);
    rx(LF_CHAR);
    read_at('0);
    read_at(IDX_W'(TAG_LEN));
    read_at({IDX_W{1'b1}});
    for (int i = 0; i < TAG_LEN; i++) rx(GGA_TAG[47-8*i -: 8]);
    rx(LF_CHAR);
    send_item(OP_RELEASE, 8'hFF, {IDX_W{1'b1}});
    send_item(OP_NOP, 8'h00, '0);
    rx(8'h00);
    rx(8'hFF);
    rx(LF_CHAR);
    read_at('0);

    // Random traffic, mostly well-formed sentences
    while (items_sent < ITEM_GOAL) begin
      send_line();
      repeat ($urandom_range(0, 5)) consumer_op();
    end
    req_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d request items, checked %0d results, %0d mismatches, %0d left over",
             items_sent, sb.results_seen, sb.mismatches, sb.pending());
    $display("Lines stored %0d, dropped for tag %0d, dropped while RMC held %0d",
             sb.ev_seen[EV_STORED], sb.ev_seen[EV_DROP_TAG], sb.ev_seen[EV_DROP_RMC]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("FAILURE");
    $finish;
  end

endmodule
